// File: rtl/lzw_pkg.sv
// Shared constants for the LZW byte compressor.
// No dependencies; imported by lzw_byte_compressor.
package lzw_pkg;

   localparam int CODE_BITS_DEF  = 12;
   localparam int HASH_SLOTS_DEF = 8192;
   localparam int FIRST_FREE     = 256;
   localparam int EPOCH_BITS     = 8;
   localparam int OUT_CODE_BITS  = 12;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 16;
   localparam int RSP_DEPTH      = 2;

   typedef struct packed {
      logic [OUT_CODE_BITS-1:0] code;
      logic                     last;
   } rsp_entry_type;

endpackage

// File: rtl/lzw_ram.sv
// Generic single-port synchronous RAM, registered read (read-first).
// No dependencies; used for the dictionary store.
module lzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// File: rtl/lzw_byte_compressor.sv
// A message's first byte only loads the prefix; other bytes are looked up at their hash along
// the linear-probe chain (one dictionary RAM read per cycle); a miss emits the prefix code.
// A last byte then emits the final code in a flush state. One transaction is worked on at a
// time. Results go through a 2-entry output queue; input is accepted only when idle, and a
// miss or flush waits while both entries are full. Reset is synchronous, active high; after
// reset and every 255 messages a clearing pass (one RAM entry per cycle) holds req_tready low.
module lzw_byte_compressor
   import lzw_pkg::*;
#(
   parameter int CODE_BITS  = CODE_BITS_DEF,
   parameter int HASH_SLOTS = HASH_SLOTS_DEF   // power of two
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [7:0] data_byte
   input  logic                     req_tlast,  // end_of_message
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [11:0] code, [15:12] zero
   output logic                     rsp_tlast   // last_code
);

   localparam int IDXW   = $clog2(HASH_SLOTS);
   localparam int KEYW   = CODE_BITS + 8;
   localparam int NCHUNK = (KEYW + IDXW - 1) / IDXW;
   localparam int WORDW  = EPOCH_BITS + KEYW + CODE_BITS;
   localparam int NFW    = CODE_BITS + 1;
   localparam int CNTW   = $clog2(RSP_DEPTH + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_PROBE = 3'd2;
   localparam logic [2:0] S_MISS  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};

   logic [2:0]            state_ff, state_in;
   logic [CODE_BITS-1:0]  prefix_ff, prefix_in;
   logic                  pvalid_ff, pvalid_in;
   logic [NFW-1:0]        next_free_ff, next_free_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [IDXW-1:0]       addr_ff, addr_in;
   logic [IDXW:0]         probes_ff, probes_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  slot_ok_ff, slot_ok_in;

   rsp_entry_type         q_ff [RSP_DEPTH];
   rsp_entry_type         q_in [RSP_DEPTH];
   logic [CNTW-1:0]       count_ff, count_in, count_left;

   logic                  ram_we;
   logic [IDXW-1:0]       ram_addr;
   logic [WORDW-1:0]      ram_wdata, ram_rdata;

   logic [EPOCH_BITS-1:0] rd_epoch;
   logic [KEYW-1:0]       rd_key;
   logic [CODE_BITS-1:0]  rd_code;

   logic [KEYW-1:0]       req_key, cur_key;
   logic [IDXW-1:0]       req_hash;
   logic [NCHUNK*IDXW-1:0] key_pad;

   logic                  accept, pop, push, space;
   rsp_entry_type         push_entry;
   logic [CODE_BITS+OUT_CODE_BITS-1:0] prefix_ext;

   lzw_ram #(
      .WIDTH (WORDW),
      .DEPTH (HASH_SLOTS)
   ) u_dict (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign {rd_epoch, rd_key, rd_code} = ram_rdata;

   assign req_key = {prefix_ff, req_tdata[7:0]};
   assign cur_key = {prefix_ff, byte_ff};
   assign key_pad = (NCHUNK*IDXW)'(req_key);

   always_comb begin
      req_hash = '0;
      for (int i = 0; i < NCHUNK; i++) begin
         req_hash = req_hash ^ key_pad[i*IDXW +: IDXW];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = RSP_DATA_BITS'(q_ff[0].code);
   assign rsp_tlast  = q_ff[0].last;
   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = (count_ff != CNTW'(RSP_DEPTH));

   assign prefix_ext = {{OUT_CODE_BITS{1'b0}}, prefix_ff};

   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      pvalid_in    = pvalid_ff;
      next_free_in = next_free_ff;
      epoch_in     = epoch_ff;
      addr_in      = addr_ff;
      probes_in    = probes_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      slot_ok_in   = slot_ok_ff;
      ram_we       = 1'b0;
      ram_addr     = addr_ff;
      ram_wdata    = '0;
      push         = 1'b0;
      push_entry.code = prefix_ext[OUT_CODE_BITS-1:0];
      push_entry.last = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == IDXW'(HASH_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               byte_in = req_tdata[7:0];
               last_in = req_tlast;
               if (!pvalid_ff) begin
                  prefix_in = CODE_BITS'(req_tdata[7:0]);
                  pvalid_in = 1'b1;
                  if (req_tlast) begin
                     state_in = S_FINAL;
                  end
               end else begin
                  ram_addr  = req_hash;
                  addr_in   = req_hash;
                  probes_in = (IDXW+1)'(1);
                  state_in  = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            priority if (rd_epoch == epoch_ff && rd_key == cur_key) begin
               prefix_in = rd_code;
               state_in  = last_ff ? S_FINAL : S_IDLE;
            end else if (rd_epoch != epoch_ff) begin
               slot_ok_in = 1'b1;
               state_in   = S_MISS;
            end else if (probes_ff == (IDXW+1)'(HASH_SLOTS)) begin
               slot_ok_in = 1'b0;
               state_in   = S_MISS;
            end else begin
               addr_in   = addr_ff + 1'b1;
               ram_addr  = addr_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
            end
         end
         S_MISS: begin
            if (space) begin
               push = 1'b1;
               if (slot_ok_ff && !next_free_ff[CODE_BITS]) begin
                  ram_we       = 1'b1;
                  ram_wdata    = {epoch_ff, cur_key, next_free_ff[CODE_BITS-1:0]};
                  next_free_in = next_free_ff + 1'b1;
               end
               prefix_in = CODE_BITS'(byte_ff);
               state_in  = last_ff ? S_FINAL : S_IDLE;
            end
         end
         S_FINAL: begin
            if (space) begin
               push            = 1'b1;
               push_entry.last = 1'b1;
               prefix_in       = '0;
               pvalid_in       = 1'b0;
               next_free_in    = NFW'(FIRST_FREE);
               if (epoch_ff == EPOCH_MAX) begin
                  epoch_in = EPOCH_BITS'(1);
                  addr_in  = '0;
                  state_in = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      q_in[0]    = q_ff[0];
      q_in[1]    = q_ff[1];
      count_left = count_ff - CNTW'(pop);
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (count_left == '0) begin
            q_in[0] = push_entry;
         end else begin
            q_in[1] = push_entry;
         end
      end
      count_in = count_left + CNTW'(push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         prefix_ff    <= '0;
         pvalid_ff    <= 1'b0;
         next_free_ff <= NFW'(FIRST_FREE);
         epoch_ff     <= EPOCH_BITS'(1);
         addr_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         pvalid_ff    <= pvalid_in;
         next_free_ff <= next_free_in;
         epoch_ff     <= epoch_in;
         addr_ff      <= addr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      probes_ff  <= probes_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      slot_ok_ff <= slot_ok_in;
      q_ff[0]    <= q_in[0];
      q_ff[1]    <= q_in[1];
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(RSP_DEPTH))
      else $error("output queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNTW'(RSP_DEPTH)))
      else $error("result pushed into full queue");

   a_code_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NFW'(1 << CODE_BITS))
      else $error("next free code beyond code space");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_MISS || state_ff == S_CLEAR))
      else $error("dictionary write outside insert or clear");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("live epoch equals the cleared mark");

endmodule
